/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, disabled while reset is high.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

/* src/chmean_pkg.sv */
// ----------------------------------------------------------------------------
// chmean_pkg
// Types and constants of the channel mean block.
// ----------------------------------------------------------------------------
package chmean_pkg;

  localparam int SUM_W            = 28;  // running sum width
  localparam int WORD_W           = 32;  // sample word width
  localparam int ID_W             = 8;   // ID byte in the low bits of a word
  localparam int DATA_W           = WORD_W - ID_W;
  localparam int MEAN_W           = 5;   // mean_count register width
  localparam int CH_W             = 6;   // channel field width
  localparam int BI_W             = 4;   // buffer index field width
  localparam int CNT_W            = $clog2(SUM_W);
  localparam int DEF_MAX_CHANNELS = 64;

  localparam logic [MEAN_W-1:0] MEAN_COUNT_RESET = MEAN_W'(2);

  typedef struct packed {
    logic        [CH_W-1:0]   channel;
    logic        [BI_W-1:0]   buffer_index;
    logic signed [WORD_W-1:0] sample_word;
  } sample_t;

  typedef struct packed {
    logic        [CH_W-1:0]   out_channel;
    logic signed [WORD_W-1:0] averaged_word;
  } mean_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ABS,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

/* src/channel_mean_with_id_byte.sv */
// ----------------------------------------------------------------------------
// channel_mean_with_id_byte
// Per-channel boxcar average of ADC sample words, keeping the ID byte of
// the first buffer of each window.
// ----------------------------------------------------------------------------
//
//   Channel     Valid          Stall          Payload           Direction
//   sample      sample_valid   sample_stall   sample  (sample_t) in
//   mean        mean_valid     mean_stall     mean    (mean_t)   out
//   config      mean_count_we  -              mean_count_wdata   in
//
// An item outside the window is dropped in its transfer cycle; one inside goes on
// from the transfer to the table update. A window close adds the magnitude step,
// a division step per sum bit on the one shared subtract/compare unit and an output load.
// Synchronous reset clears the sequencer, mean_valid and mean_count (back to 2)
// but not the tables. sample_stall is high while an item is in work; a result held
// under mean_stall blocks only the next window close until the output is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module channel_mean_with_id_byte #(
  parameter int MAX_CHANNELS = chmean_pkg::DEF_MAX_CHANNELS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  chmean_pkg::sample_t         sample,
  output logic                        mean_valid,
  input  logic                        mean_stall,
  output chmean_pkg::mean_t           mean,
  input  logic                        mean_count_we,
  input  logic [chmean_pkg::MEAN_W-1:0] mean_count_wdata
);

  import chmean_pkg::*;

  localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Configuration register.
  logic [MEAN_W-1:0] mean_count;

  // Sequencer.
  state_t state, state_next;

  // Item being worked on.
  logic [CH_W-1:0]   cur_channel;
  logic [CH_AW-1:0]  cur_addr;
  logic [BI_W-1:0]   cur_bi;
  logic [WORD_W-1:0] cur_word;

  // Per-channel tables, read data registered.
  logic [SUM_W-1:0] sum_mem [MAX_CHANNELS];
  logic [ID_W-1:0]  id_mem  [MAX_CHANNELS];
  logic [SUM_W-1:0] rd_sum;
  logic [ID_W-1:0]  rd_id;

  // Divider state: the dividend register turns into the quotient as its bits
  // are shifted out at the top into the remainder and quotient bits come in at the bottom.
  logic [SUM_W-1:0]  dividend;
  logic [MEAN_W-1:0] rem;
  logic [CNT_W-1:0]  div_cnt;
  logic              neg;
  logic [ID_W-1:0]   res_id;

  // Control decoded from the state.
  logic              accept;
  logic              item_ok;
  logic              is_last;
  logic              out_free;
  logic [CH_AW-1:0]  in_addr;

  // Datapath of the update step.
  logic [SUM_W-1:0]  data_ext;
  logic [SUM_W-1:0]  new_sum;
  logic [ID_W-1:0]   new_id;

  // Shared subtract/compare of the divider.
  logic [MEAN_W:0]   trial;
  logic [MEAN_W:0]   trial_diff;
  logic              q_bit;

  // Result forming.
  logic [SUM_W-1:0]  quotient;

  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign in_addr      = CH_AW'(sample.channel);
  // A channel beyond the table and an index outside the window are dropped
  // right at the transfer, leaving the sequencer and the tables untouched.
  assign item_ok      = (32'(sample.channel) < MAX_CHANNELS) &&
                        ({1'b0, sample.buffer_index} < mean_count);
  assign out_free     = !mean_valid || !mean_stall;

  // The 24-bit data field, sign-extended into the sum width.
  assign data_ext = SUM_W'($signed(cur_word[WORD_W-1:ID_W]));
  assign new_sum  = (cur_bi == '0) ? data_ext : (rd_sum + data_ext);
  assign new_id   = (cur_bi == '0) ? cur_word[ID_W-1:0] : rd_id;
  // mean_count is at least one here, so the add cannot wrap.
  assign is_last  = ((MEAN_W'(cur_bi) + MEAN_W'(1)) == mean_count);

  // One restoring division step per cycle.
  assign trial      = {rem, dividend[SUM_W-1]};
  assign trial_diff = trial - {1'b0, mean_count};
  assign q_bit      = (trial >= {1'b0, mean_count});

  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign quotient = neg ? (~dividend + SUM_W'(1)) : dividend;

  // Configuration register; the user writes it only while the block is idle; unenforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_count <= MEAN_COUNT_RESET;
    end else if (mean_count_we) begin
      mean_count <= mean_count_wdata;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && item_ok) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = is_last ? ST_ABS : ST_IDLE;
      end
      ST_ABS: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == CNT_W'(SUM_W - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Table access: read at the transfer, written back in the update step.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_sum <= sum_mem[in_addr];
      rd_id  <= id_mem[in_addr];
    end
    if (state == ST_UPDATE) begin
      sum_mem[cur_addr] <= new_sum;
      id_mem[cur_addr]  <= new_id;
    end
  end

  // Item and divider registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_channel <= sample.channel;
      cur_addr    <= in_addr;
      cur_bi      <= sample.buffer_index;
      cur_word    <= sample.sample_word;
    end
    unique case (state)
      ST_UPDATE: begin
        dividend <= new_sum;
        neg      <= new_sum[SUM_W-1];
        res_id   <= new_id;
      end
      ST_ABS: begin
        if (neg) begin
          dividend <= ~dividend + SUM_W'(1);
        end
        rem     <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        rem      <= q_bit ? trial_diff[MEAN_W-1:0] : trial[MEAN_W-1:0];
        dividend <= {dividend[SUM_W-2:0], q_bit};
        div_cnt  <= div_cnt + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register; the low bits of the quotient land above the ID byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      mean_valid <= 1'b1;
    end else if (!mean_stall) begin
      mean_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      mean.out_channel   <= cur_channel;
      mean.averaged_word <= {quotient[DATA_W-1:0], res_id};
    end
  end

  // The remainder of a restoring divider always stays below the divisor.
  `ASSERT_PROP(a_rem_below_div, clk, rst, (state == ST_DIV) |-> (rem < mean_count))
  // A divide never runs with a zero divisor.
  `ASSERT_NEVER(a_div_by_zero, clk, rst, (state == ST_DIV) && (mean_count == '0))
  // A new result shows up only after the divider handed one over.
  `ASSERT_PROP(a_result_source, clk, rst,
    (mean_valid && !$past(mean_valid)) |-> ($past(state) == ST_EMIT))
  // A valid item inside the window always goes on to the table update.
  `ASSERT_PROP(a_item_update, clk, rst, (accept && item_ok) |=> (state == ST_UPDATE))

endmodule

/* dv/channel_mean_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_mean_checker
// Watches the sample, mean and configuration ports of the channel mean
// block, predicts every averaged word and compares it with what comes out.
// ----------------------------------------------------------------------------
module channel_mean_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  input  logic                          sample_stall,
  input  chmean_pkg::sample_t           sample,
  input  logic                          mean_valid,
  input  logic                          mean_stall,
  input  chmean_pkg::mean_t             mean,
  input  logic                          mean_count_we,
  input  logic [chmean_pkg::MEAN_W-1:0] mean_count_wdata,
  output int                            pending,
  output int                            failures
);

  import chmean_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Shadow of the block's state: window length, running sums and ID bytes.
  logic        [MEAN_W-1:0] window_len;
  logic signed [SUM_W-1:0]  running_sum [DEF_MAX_CHANNELS];
  logic        [ID_W-1:0]   first_id    [DEF_MAX_CHANNELS];

  mean_t expected_means [$];
  int    reported;

  initial begin
    pending  = 0;
    failures = 0;
    reported = 0;
  end

  // Applies one sample to the shadow state; returns 1 when it closes a window.
  function automatic bit average_sample(input sample_t s, output mean_t m);
    logic signed [SUM_W-1:0] data;
    longint                  total;
    longint                  quot;
    data = {{(SUM_W - DATA_W){s.sample_word[WORD_W-1]}}, s.sample_word[WORD_W-1:ID_W]};
    m = '0;
    if (MEAN_W'(s.buffer_index) >= window_len) return 1'b0;
    if (s.buffer_index == '0) begin
      running_sum[s.channel] = data;
      first_id[s.channel]    = s.sample_word[ID_W-1:0];
    end else begin
      running_sum[s.channel] = running_sum[s.channel] + data;
    end
    if (MEAN_W'(s.buffer_index) != window_len - MEAN_W'(1)) return 1'b0;
    total = longint'(running_sum[s.channel]);
    quot  = total / longint'(window_len);
    m.out_channel   = s.channel;
    m.averaged_word = {quot[WORD_W-ID_W-1:0], first_id[s.channel]};
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    mean_t want;
    mean_t got;
    if (rst) begin
      window_len = MEAN_COUNT_RESET;
      expected_means.delete();
    end else begin
      if (mean_count_we) window_len = mean_count_wdata;

      if (mean_valid && !mean_stall) begin
        got = mean;
        if (expected_means.size() == 0) begin
          failures++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("unexpected mean: channel %0d word %h", got.out_channel,
                     got.averaged_word);
          end
        end else begin
          want = expected_means.pop_front();
          if (got.out_channel !== want.out_channel ||
              got.averaged_word !== want.averaged_word) begin
            failures++;
            if (reported < REPORT_LIMIT) begin
              reported++;
              $display("mean mismatch: channel exp %0d got %0d, word exp %h got %h",
                       want.out_channel, got.out_channel, want.averaged_word,
                       got.averaged_word);
            end
          end
        end
      end

      if (sample_valid && !sample_stall) begin
        if (average_sample(sample, want)) expected_means.push_back(want);
      end
    end
    pending = expected_means.size();
  end

endmodule

/* dv/channel_mean_with_id_byte_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_mean_with_id_byte_tb
// Drives sample words through the channel mean block over several window
// lengths, with random bursts on the input and random stalls on the output.
// A checker beside the block predicts every averaged word.
// ----------------------------------------------------------------------------
module channel_mean_with_id_byte_tb;
  import chmean_pkg::*;

  localparam int PHASE_ITEMS      = 200;  // counted samples per random phase
  localparam int SETTLE_CYCLES    = 40;   // a little over one full item of work
  localparam int FILL_HOLD_CYCLES = 400;  // long output hold-off

  // Kinds of random sequences sent to the block.
  typedef enum int {
    SEQ_WINDOW,    // a complete window in order
    SEQ_BROKEN,    // random indices: repeats, gaps, restarts
    SEQ_LONG_SUM,  // many large same-sign adds to push the sum to wrap
    SEQ_IGNORED    // indices beyond the window, which the block drops
  } seq_kind_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              sample_valid;
  logic              sample_stall;
  sample_t           sample;
  logic              mean_valid;
  logic              mean_stall;
  mean_t             mean;
  logic              mean_count_we;
  logic [MEAN_W-1:0] mean_count_wdata;
  int                pending;
  int                failures;

  // Window length currently programmed, as the stimulus knows it.
  int mean_setting;
  // Channels whose window has been started at least once since reset. The
  // sum table is undefined until then, so no accumulate may reach it.
  bit channel_started [DEF_MAX_CHANNELS];
  // Samples sent in the current phase that the block actually works on.
  int window_items;
  // Remaining transfers in the current input burst.
  int burst_left;
  // Handshake between the stimulus and the receiver for the long hold-off.
  bit fill_hold_req;
  bit fill_hold_done;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  channel_mean_with_id_byte i_dut (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .sample           (sample),
    .mean_valid       (mean_valid),
    .mean_stall       (mean_stall),
    .mean             (mean),
    .mean_count_we    (mean_count_we),
    .mean_count_wdata (mean_count_wdata)
  );

  channel_mean_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .sample           (sample),
    .mean_valid       (mean_valid),
    .mean_stall       (mean_stall),
    .mean             (mean),
    .mean_count_we    (mean_count_we),
    .mean_count_wdata (mean_count_wdata),
    .pending          (pending),
    .failures         (failures)
  );

  // Sends one sample word and returns at the edge where it is transferred.
  // The sender works in bursts: when a burst runs out, valid may drop for a
  // random gap before the next one starts. A zero gap keeps valid high.
  task automatic send_sample(input int ch, input int bi, input logic [WORD_W-1:0] word);
    sample_t s;
    int      gap;
    // An accumulate into a channel that never saw buffer 0 would read an
    // undefined sum, so such an item is turned into a window start.
    if (bi != 0 && bi < mean_setting && !channel_started[ch]) bi = 0;
    if (bi == 0) channel_started[ch] = 1'b1;
    if (bi < mean_setting) window_items++;

    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 100);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 20);
        gap        = $urandom_range(0, 10);
      end
      if (gap > 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;

    s.channel      = CH_W'(ch);
    s.buffer_index = BI_W'(bi);
    s.sample_word  = word;
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // Lets the block drain: every expected mean must have come out, then a
  // few more cycles cover an item still in work that produces nothing.
  task automatic drain_block();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reprograms the window length once the block has gone idle.
  task automatic set_mean_count(input int value);
    drain_block();
    mean_count_we    <= 1'b1;
    mean_count_wdata <= MEAN_W'(value);
    @(posedge clk);
    mean_count_we    <= 1'b0;
    mean_setting   = value;
    window_items   = 0;
  endtask

  // Word with data near full scale of one sign and random low bits and ID.
  function automatic logic [WORD_W-1:0] near_full_scale(input bit negative);
    logic [15:0] low;
    low = 16'($urandom());
    if (negative) return {1'b1, 7'h00, low, 8'($urandom())};
    return {1'b0, 7'h7f, low, 8'($urandom())};
  endfunction

  task automatic run_sequence(input seq_kind_t kind);
    int ch;
    int n;
    bit negative;
    ch = $urandom_range(0, DEF_MAX_CHANNELS - 1);
    case (kind)
      SEQ_WINDOW: begin
        for (int bi = 0; bi < mean_setting; bi++) send_sample(ch, bi, $urandom());
      end
      SEQ_BROKEN: begin
        n = $urandom_range(1, mean_setting + 3);
        for (int k = 0; k < n; k++) begin
          send_sample(ch, $urandom_range(0, mean_setting - 1), $urandom());
        end
      end
      SEQ_LONG_SUM: begin
        // Needs room for a middle index that adds without closing the window.
        if (mean_setting < 3) begin
          run_sequence(SEQ_WINDOW);
        end else begin
          negative = $urandom_range(0, 1);
          n = $urandom_range(12, 40);
          send_sample(ch, 0, near_full_scale(negative));
          for (int k = 0; k < n; k++) begin
            send_sample(ch, $urandom_range(1, mean_setting - 2), near_full_scale(negative));
          end
          send_sample(ch, mean_setting - 1, near_full_scale(negative));
        end
      end
      SEQ_IGNORED: begin
        if (mean_setting > 15) begin
          run_sequence(SEQ_WINDOW);
        end else begin
          n = $urandom_range(1, 4);
          for (int k = 0; k < n; k++) begin
            send_sample(ch, $urandom_range(mean_setting, 15), $urandom());
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic run_random_phase(input int value);
    int pick;
    set_mean_count(value);
    while (window_items < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)      run_sequence(SEQ_WINDOW);
      else if (pick < 82) run_sequence(SEQ_BROKEN);
      else if (pick < 92) run_sequence(SEQ_LONG_SUM);
      else                run_sequence(SEQ_IGNORED);
    end
  endtask

  // Stimulus: reset, a directed part, then random phases over window lengths.
  initial begin
    int phase_lengths [8];
    rst              = 1'b1;
    sample_valid     = 1'b0;
    sample           = '0;
    mean_count_we    = 1'b0;
    mean_count_wdata = '0;
    mean_setting     = MEAN_COUNT_RESET;
    window_items     = 0;
    burst_left       = 0;
    fill_hold_req    = 1'b0;
    phase_lengths    = '{16, 1, 2, 9, 16, 4, 1, 0};
    phase_lengths[7] = $urandom_range(1, 16);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Window of one: every start emits at once. Most negative and most
    // positive data with the lowest and highest ID bytes, on the first and
    // last channel, then two items outside the window.
    set_mean_count(1);
    send_sample(0, 0, 32'h8000_0000);
    send_sample(DEF_MAX_CHANNELS - 1, 0, 32'h7fff_ffff);
    send_sample(5, 15, 32'h1234_5678);
    send_sample(42, 1, 32'hdead_beef);

    // Window of three with the middle index repeated: eighteen full-scale
    // positive samples overflow the sum, which wraps negative. The negative
    // quotient is truncated toward zero and is wider than 24 bits, so the
    // shift into place drops its top bits.
    set_mean_count(3);
    send_sample(17, 0, 32'h7fff_ffa5);
    for (int k = 0; k < 16; k++) send_sample(17, 1, 32'h7fff_ff00 | 32'(k));
    send_sample(17, 2, 32'h7fff_ffff);

    // Random phases. The first one also asks the receiver for its long
    // hold-off so that the output backs up and the block stalls its input.
    for (int p = 0; p < 8; p++) begin
      if (p == 0) fill_hold_req = 1'b1;
      run_random_phase(phase_lengths[p]);
    end

    drain_block();
    if (failures == 0) begin
      $display("channel_mean_with_id_byte_tb OK");
    end else begin
      $display("channel_mean_with_id_byte_tb NOT OK");
    end
    $finish;
  end

  // Receiver: stretches of no stall, random stall and a fixed stall pattern,
  // plus one long hold-off while the sender keeps offering samples.
  initial begin
    int mode;
    int run;
    mean_stall     = 1'b0;
    fill_hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (fill_hold_req && !fill_hold_done) begin
        mean_stall <= 1'b1;
        repeat (FILL_HOLD_CYCLES) @(posedge clk);
        fill_hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        run  = $urandom_range(5, 60);
        for (int i = 0; i < run; i++) begin
          case (mode)
            0:       mean_stall <= 1'b0;
            1:       mean_stall <= 1'($urandom_range(0, 1));
            default: mean_stall <= (i % 4 != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Run limit: several times the slowest correct run.
  initial begin
    #8_000_000;
    $display("channel_mean_with_id_byte_tb NOT OK");
    $finish;
  end

endmodule
